// ----- hw/rtl/length_prefixed_key_table_defines.svh -----
// Assertion macros used by the key table sequencer RTL.
`ifndef LENGTH_PREFIXED_KEY_TABLE_DEFINES_SVH
`define LENGTH_PREFIXED_KEY_TABLE_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define LPKT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define LPKT_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LPKT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/lpkt_pkg.sv -----
// Types and constants for the length-prefixed key table.
package lpkt_pkg;

  localparam int LEN_W = 8;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_KEY_LONG = 2'd2;

  typedef enum logic [2:0] {
    S_COLLECT,
    S_INS_HDR,
    S_INS_COPY,
    S_SCAN_RD,
    S_SCAN_LEN,
    S_CMP,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic       valid;
    logic       found;
    logic [1:0] status;
  } res_t;

endpackage

// ----- hw/rtl/lpkt_ram.sv -----
// Simple dual-port byte RAM with registered read data.
module lpkt_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/lpkt_seq.sv -----
// Sequencer: key collection, insert copy and linear table scan.
`include "length_prefixed_key_table_defines.svh"

module lpkt_seq #(
  parameter int TABLE_BYTES   = 4096,
  parameter int MAX_KEY_BYTES = 255,
  parameter int AW            = $clog2(TABLE_BYTES),
  parameter int KW            = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cmd,
  input  logic [7:0]           key_byte,
  input  logic                 key_last,
  input  logic                 res_ready,
  output lpkt_pkg::res_t       res,
  output logic                 tbl_we,
  output logic [AW-1:0]        tbl_waddr,
  output logic [7:0]           tbl_wdata,
  output logic [AW-1:0]        tbl_raddr,
  input  logic [7:0]           tbl_rdata,
  output logic                 kb_we,
  output logic [KW-1:0]        kb_waddr,
  output logic [7:0]           kb_wdata,
  output logic [KW-1:0]        kb_raddr,
  input  logic [7:0]           kb_rdata
);
  import lpkt_pkg::*;

  localparam int CW = $clog2(TABLE_BYTES + 1);
  localparam int PW = $clog2(TABLE_BYTES + 257);

  state_t             state, state_next;
  logic [CW-1:0]      fill, fill_next;
  logic [PW-1:0]      pos, pos_next;
  logic [AW-1:0]      tptr, tptr_next;
  logic [LEN_W-1:0]   kidx, kidx_next;
  logic [LEN_W-1:0]   ent_len, ent_len_next;
  logic [LEN_W-1:0]   key_len, key_len_next;
  logic               key_ovf, key_ovf_next;
  logic               res_found, res_found_next;
  logic [1:0]         res_status, res_status_next;

  logic               acc;
  logic               has_room;
  logic               ovf_now;
  logic [LEN_W-1:0]   len_fin;
  logic               fits;
  logic               scan_end;
  logic               hit_len;
  logic               byte_eq;
  logic               cmp_last;
  logic               copy_last;
  logic [PW-1:0]      pos_skip_rd;
  logic [PW-1:0]      pos_skip_ent;

  assign acc       = in_valid && (state == S_COLLECT);
  assign in_stall  = (state != S_COLLECT);
  assign has_room  = key_len < LEN_W'(MAX_KEY_BYTES);
  assign ovf_now   = key_ovf || !has_room;
  assign len_fin   = key_len + LEN_W'(1);
  assign fits      = ({1'b0, fill} + (CW+1)'(len_fin) + (CW+1)'(1))
                     <= (CW+1)'(TABLE_BYTES);
  assign scan_end  = pos >= PW'(fill);
  assign pos_skip_rd  = pos + PW'(tbl_rdata) + PW'(1);
  assign pos_skip_ent = pos + PW'(ent_len) + PW'(1);
  assign hit_len   = (tbl_rdata == key_len) && (pos_skip_rd <= PW'(fill));
  assign byte_eq   = tbl_rdata == kb_rdata;
  assign cmp_last  = kidx == (ent_len - LEN_W'(1));
  assign copy_last = kidx == (key_len - LEN_W'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_COLLECT: begin
        if (acc && key_last) begin
          if (ovf_now) begin
            state_next = S_RESULT;
          end else if (cmd == CMD_INSERT) begin
            state_next = fits ? S_INS_HDR : S_RESULT;
          end else begin
            state_next = S_SCAN_RD;
          end
        end
      end
      S_INS_HDR:  state_next = S_INS_COPY;
      S_INS_COPY: state_next = copy_last ? S_RESULT : S_INS_COPY;
      S_SCAN_RD:  state_next = scan_end ? S_RESULT : S_SCAN_LEN;
      S_SCAN_LEN: state_next = hit_len ? S_CMP : S_SCAN_RD;
      S_CMP: begin
        if (!byte_eq) begin
          state_next = S_SCAN_RD;
        end else if (cmp_last) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_CMP;
        end
      end
      S_RESULT:   state_next = res_ready ? S_COLLECT : S_RESULT;
      default:    state_next = S_COLLECT;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    fill_next       = fill;
    pos_next        = pos;
    tptr_next       = tptr;
    kidx_next       = kidx;
    ent_len_next    = ent_len;
    key_len_next    = key_len;
    key_ovf_next    = key_ovf;
    res_found_next  = res_found;
    res_status_next = res_status;
    tbl_we          = 1'b0;
    tbl_waddr       = tptr;
    tbl_wdata       = kb_rdata;
    tbl_raddr       = pos[AW-1:0];
    kb_we           = 1'b0;
    kb_waddr        = key_len[KW-1:0];
    kb_wdata        = key_byte;
    kb_raddr        = '0;
    res.valid       = 1'b0;
    res.found       = res_found;
    res.status      = res_status;
    unique case (state)
      S_COLLECT: begin
        if (acc) begin
          if (has_room) begin
            kb_we        = 1'b1;
            key_len_next = len_fin;
          end else begin
            key_ovf_next = 1'b1;
          end
          if (key_last) begin
            pos_next       = '0;
            res_found_next = 1'b0;
            if (ovf_now) begin
              res_status_next = ST_KEY_LONG;
            end else if (cmd == CMD_INSERT && !fits) begin
              res_status_next = ST_FULL;
            end else begin
              res_status_next = ST_OK;
            end
          end
        end
      end
      S_INS_HDR: begin
        tbl_we    = 1'b1;
        tbl_waddr = fill[AW-1:0];
        tbl_wdata = key_len;
        tptr_next = fill[AW-1:0] + AW'(1);
        kidx_next = '0;
      end
      S_INS_COPY: begin
        tbl_we    = 1'b1;
        tptr_next = tptr + AW'(1);
        kidx_next = kidx + LEN_W'(1);
        kb_raddr  = kidx_next[KW-1:0];
        if (copy_last) begin
          fill_next = fill + CW'(key_len) + CW'(1);
        end
      end
      S_SCAN_RD: begin
        tbl_raddr = pos[AW-1:0];
      end
      S_SCAN_LEN: begin
        ent_len_next = tbl_rdata;
        if (hit_len) begin
          tbl_raddr = AW'(pos + PW'(1));
          tptr_next = AW'(pos + PW'(2));
          kb_raddr  = '0;
          kidx_next = '0;
        end else begin
          pos_next = pos_skip_rd;
        end
      end
      S_CMP: begin
        if (!byte_eq) begin
          pos_next = pos_skip_ent;
        end else if (cmp_last) begin
          res_found_next = 1'b1;
        end else begin
          tbl_raddr = tptr;
          tptr_next = tptr + AW'(1);
          kidx_next = kidx + LEN_W'(1);
          kb_raddr  = kidx_next[KW-1:0];
        end
      end
      S_RESULT: begin
        res.valid = 1'b1;
        if (res_ready) begin
          key_len_next = '0;
          key_ovf_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_COLLECT;
      fill    <= '0;
      key_len <= '0;
      key_ovf <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      key_len <= key_len_next;
      key_ovf <= key_ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    tptr       <= tptr_next;
    kidx       <= kidx_next;
    ent_len    <= ent_len_next;
    res_found  <= res_found_next;
    res_status <= res_status_next;
  end

  `LPKT_ASSERT_ALWAYS(a_fill_bound, fill <= CW'(TABLE_BYTES), "fill cursor past table end")
  `LPKT_ASSERT_ALWAYS(a_key_len_bound, key_len <= LEN_W'(MAX_KEY_BYTES), "key length past limit")
  `LPKT_ASSERT_IMPLIES(a_found_ok, res.valid && res.found, res.status == ST_OK, "found with error")
  `LPKT_ASSERT_NEXT(a_fill_hold, state != S_INS_COPY, $stable(fill), "fill moved outside insert")
  `LPKT_ASSERT_NEXT(a_key_clear, state == S_RESULT && res_ready, key_len == '0 && !key_ovf,
                    "key state not cleared after result")

endmodule

// ----- hw/rtl/length_prefixed_key_table.sv -----
// Length-prefixed key table: top level with memories and output register.
//
// Input channel (in_valid/in_stall, fields cmd, key_byte, key_last) carries
// one key byte per request; key_last marks the final byte, whose cmd selects
// insert or lookup. Output channel (out_valid/out_stall, fields found,
// status) returns one result per final byte.
// A non-final byte is taken whenever in_stall is low. From the edge that
// takes a final byte to its result: a rejected key (too long, table full)
// goes straight to the result; an insert writes the length header, then
// copies the key bytes, one table write per cycle. A lookup reads each
// visited entry's length, then compares bytes up to a mismatch, a hit or
// the table end; length reads and byte compares share one table read port.
// in_stall is high from a final byte until its result is loaded into the
// output register; the next key's bytes are taken while that result waits.
// A stalled output holds its result; the sequencer waits to load the next.
// Reset empties the table and clears the key collector at once; no
// clearing pass is needed.
module length_prefixed_key_table #(
  parameter int TABLE_BYTES   = 4096,
  parameter int MAX_KEY_BYTES = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd,
  input  logic [7:0] key_byte,
  input  logic       key_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       found,
  output logic [1:0] status
);
  import lpkt_pkg::*;

  localparam int AW = $clog2(TABLE_BYTES);
  localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  res_t          res;
  logic          res_ready;
  logic          tbl_we;
  logic [AW-1:0] tbl_waddr;
  logic [7:0]    tbl_wdata;
  logic [AW-1:0] tbl_raddr;
  logic [7:0]    tbl_rdata;
  logic          kb_we;
  logic [KW-1:0] kb_waddr;
  logic [7:0]    kb_wdata;
  logic [KW-1:0] kb_raddr;
  logic [7:0]    kb_rdata;

  assign res_ready = !out_valid || !out_stall;

  lpkt_seq #(
    .TABLE_BYTES  (TABLE_BYTES),
    .MAX_KEY_BYTES(MAX_KEY_BYTES),
    .AW           (AW),
    .KW           (KW)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .key_byte (key_byte),
    .key_last (key_last),
    .res_ready(res_ready),
    .res      (res),
    .tbl_we   (tbl_we),
    .tbl_waddr(tbl_waddr),
    .tbl_wdata(tbl_wdata),
    .tbl_raddr(tbl_raddr),
    .tbl_rdata(tbl_rdata),
    .kb_we    (kb_we),
    .kb_waddr (kb_waddr),
    .kb_wdata (kb_wdata),
    .kb_raddr (kb_raddr),
    .kb_rdata (kb_rdata)
  );

  lpkt_ram #(
    .DEPTH(TABLE_BYTES),
    .WIDTH(8),
    .AW   (AW)
  ) u_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(tbl_waddr),
    .wdata(tbl_wdata),
    .raddr(tbl_raddr),
    .rdata(tbl_rdata)
  );

  lpkt_ram #(
    .DEPTH(MAX_KEY_BYTES),
    .WIDTH(8),
    .AW   (KW)
  ) u_key_buf (
    .clk  (clk),
    .we   (kb_we),
    .waddr(kb_waddr),
    .wdata(kb_wdata),
    .raddr(kb_raddr),
    .rdata(kb_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      found  <= res.found;
      status <= res.status;
    end
  end

endmodule
